>>> hw/rtl/vcfu_pkg.sv
package vcfu_pkg;

  localparam int unsigned Lanes     = 2;
  localparam int unsigned ElemWidth = 32;
  localparam int unsigned FlagBits  = 7;
  localparam int unsigned VecWidth  = 64;
  localparam int unsigned VFlagWidth = 14;

  typedef logic [FlagBits-1:0]  flags_t;
  typedef logic [ElemWidth-1:0] elem_t;

  typedef enum logic [1:0] {
    CmdScalar   = 2'd0,
    CmdBcastA   = 2'd1,
    CmdBcastB   = 2'd2,
    CmdElemwise = 2'd3
  } cmd_e;

  localparam flags_t FlagEq = 7'h01;
  localparam flags_t FlagNe = 7'h02;
  localparam flags_t FlagLe = 7'h04;
  localparam flags_t FlagGe = 7'h08;
  localparam flags_t FlagLt = 7'h10;
  localparam flags_t FlagGt = 7'h20;
  localparam flags_t FlagAl = 7'h40;

  // Per-item control seen by every lane
  typedef struct packed {
    logic a_float;
    logic b_float;
  } lane_ctrl_t;

  typedef struct packed {
    logic [1:0]            command;
    logic                  first_is_immediate;
    logic                  first_is_float;
    logic                  second_is_float;
    logic [ElemWidth-1:0]  first_scalar;
    logic [ElemWidth-1:0]  second_scalar;
    logic [VecWidth-1:0]   first_vector;
    logic [VecWidth-1:0]   second_vector;
    logic [FlagBits-1:0]   old_scalar_flags;
    logic [VFlagWidth-1:0] old_vector_flags;
  } req_t;

  typedef struct packed {
    logic [FlagBits-1:0]   new_scalar_flags;
    logic [VFlagWidth-1:0] new_vector_flags;
  } rsp_t;

endpackage

>>> hw/rtl/vcfu_req_if.sv
interface vcfu_req_if;
  import vcfu_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/vcfu_rsp_if.sv
interface vcfu_rsp_if;
  import vcfu_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/vcfu_lane.sv
module vcfu_lane (
  input  vcfu_pkg::lane_ctrl_t ctrl_i,
  input  vcfu_pkg::elem_t      a_i,
  input  vcfu_pkg::elem_t      b_i,
  input  vcfu_pkg::flags_t     old_i,
  output vcfu_pkg::flags_t     flags_o
);
  import vcfu_pkg::*;

  logic  a_nan, b_nan, both_zero, eq, lt;
  elem_t ka, kb;

  // Order keys: sign flip for integers, sign-magnitude map for floats
  always_comb begin
    if (ctrl_i.a_float) begin
      ka = a_i[ElemWidth-1] ? ~a_i : (a_i | {1'b1, {(ElemWidth-1){1'b0}}});
      kb = b_i[ElemWidth-1] ? ~b_i : (b_i | {1'b1, {(ElemWidth-1){1'b0}}});
    end else begin
      ka = a_i ^ {1'b1, {(ElemWidth-1){1'b0}}};
      kb = b_i ^ {1'b1, {(ElemWidth-1){1'b0}}};
    end
  end

  assign a_nan     = (&a_i[30:23]) && (|a_i[22:0]);
  assign b_nan     = (&b_i[30:23]) && (|b_i[22:0]);
  assign both_zero = (a_i[30:0] == '0) && (b_i[30:0] == '0);
  assign eq        = (ka == kb) || (ctrl_i.a_float && both_zero);
  assign lt        = ka < kb;

  always_comb begin
    if (ctrl_i.a_float != ctrl_i.b_float) begin
      flags_o = old_i;
    end else if (ctrl_i.a_float && (a_nan || b_nan)) begin
      flags_o = FlagNe | FlagAl;
    end else if (eq) begin
      flags_o = FlagAl | FlagEq | FlagLe | FlagGe;
    end else if (lt) begin
      flags_o = FlagAl | FlagNe | FlagLe | FlagLt;
    end else begin
      flags_o = FlagAl | FlagNe | FlagGe | FlagGt;
    end
  end

endmodule

>>> hw/rtl/vector_compare_flag_unit.sv
// Compare unit: one request per clock unless stalled; result the next cycle.
// Lanes+1 compare lanes (one scalar, Lanes vector) run in parallel; the
// merge stage picks scalar or per-lane flags by command into a single output
// register. A new request is taken whenever the output register is empty or
// is being drained in the same cycle, so throughput is one per cycle.
module vector_compare_flag_unit (
  input logic       clk_i,
  input logic       rst_ni,
  vcfu_req_if.sink   req_i,
  vcfu_rsp_if.source rsp_o
);
  import vcfu_pkg::*;

  req_t       r;
  lane_ctrl_t ctrl;
  logic       a_vec, b_vec;
  flags_t     sflags;
  flags_t     vflags [Lanes];
  logic       valid_q;
  rsp_t       data_q, data_d;

  // Immediate forces a scalar first operand typed as the second
  always_comb begin
    r          = req_i.data;
    ctrl.b_float = r.second_is_float;
    ctrl.a_float = r.first_is_immediate ? r.second_is_float : r.first_is_float;
    a_vec = r.command[1] && !r.first_is_immediate;
    b_vec = r.command[0];
  end

  vcfu_lane u_scalar (
    .ctrl_i(ctrl), .a_i(r.first_scalar), .b_i(r.second_scalar),
    .old_i(r.old_scalar_flags), .flags_o(sflags)
  );

  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    vcfu_lane u_lane (
      .ctrl_i (ctrl),
      .a_i    (a_vec ? r.first_vector[i*ElemWidth +: ElemWidth] : r.first_scalar),
      .b_i    (b_vec ? r.second_vector[i*ElemWidth +: ElemWidth] : r.second_scalar),
      .old_i  (r.old_vector_flags[i*FlagBits +: FlagBits]),
      .flags_o(vflags[i])
    );
  end

  // Merge lanes by command
  always_comb begin
    data_d.new_scalar_flags = r.old_scalar_flags;
    data_d.new_vector_flags = r.old_vector_flags;
    if (!a_vec && !b_vec) begin
      data_d.new_scalar_flags = sflags;
    end else begin
      for (int i = 0; i < Lanes; i++) begin
        data_d.new_vector_flags[i*FlagBits +: FlagBits] = vflags[i];
      end
    end
  end

  assign req_i.ready = !valid_q || rsp_o.ready;
  assign rsp_o.valid = valid_q;
  assign rsp_o.data  = data_q;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      data_q <= data_d;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_o.data))
    else $error("result lost or changed under stall");

  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> rsp_o.valid)
    else $error("accepted request gave no result");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_o.valid |-> req_i.ready)
    else $error("idle unit not ready");

endmodule

>>> tb/sv/vector_compare_flag_unit_tb.sv
`timescale 1ns / 1ps

module vector_compare_flag_unit_tb;
  import vcfu_pkg::*;

  localparam int unsigned StallLimit = 2000;

  // Flag word predictor
  function automatic flags_t order_flags(int ord);
    flags_t f;
    f = FlagAl;
    if (ord == 0) f |= FlagEq | FlagLe | FlagGe;
    else if (ord < 0) f |= FlagNe | FlagLe | FlagLt;
    else f |= FlagNe | FlagGe | FlagGt;
    return f;
  endfunction

  function automatic logic [31:0] fkey(elem_t x);
    return x[31] ? ~x : (x | 32'h8000_0000);
  endfunction

  function automatic flags_t pair_flags(logic fa, logic fb, elem_t a, elem_t b,
                                        flags_t old);
    logic [31:0] ka, kb;
    logic na, nb;
    if (!fa && !fb) begin
      ka = a ^ 32'h8000_0000;
      kb = b ^ 32'h8000_0000;
      return order_flags(ka == kb ? 0 : (ka < kb ? -1 : 1));
    end
    if (fa != fb) return old;
    na = (a[30:23] == 8'hff) && (a[22:0] != 0);
    nb = (b[30:23] == 8'hff) && (b[22:0] != 0);
    if (na || nb) return FlagNe | FlagAl;
    if (a[30:0] == 0 && b[30:0] == 0) return order_flags(0);
    ka = fkey(a);
    kb = fkey(b);
    return order_flags(ka == kb ? 0 : (ka < kb ? -1 : 1));
  endfunction

  function automatic rsp_t predict_flags(req_t r);
    rsp_t o;
    logic [1:0] cmd;
    logic fa, avec, bvec;
    elem_t a, b;
    cmd = r.command;
    fa = r.first_is_float;
    o.new_scalar_flags = r.old_scalar_flags;
    o.new_vector_flags = r.old_vector_flags;
    if (r.first_is_immediate) begin
      fa = r.second_is_float;
      cmd[1] = 1'b0;
    end
    avec = cmd[1];
    bvec = cmd[0];
    if (!avec && !bvec) begin
      o.new_scalar_flags = pair_flags(fa, r.second_is_float, r.first_scalar,
                                      r.second_scalar, r.old_scalar_flags);
    end else begin
      for (int i = 0; i < Lanes; i++) begin
        a = avec ? r.first_vector[i*32 +: 32] : r.first_scalar;
        b = bvec ? r.second_vector[i*32 +: 32] : r.second_scalar;
        o.new_vector_flags[i*FlagBits +: FlagBits] = pair_flags(fa, r.second_is_float,
            a, b, r.old_vector_flags[i*FlagBits +: FlagBits]);
      end
    end
    return o;
  endfunction

  class flag_scoreboard;
    rsp_t pending[$];
    int errors;
    function void note_request(req_t r);
      pending = {pending, predict_flags(r)};
    endfunction
    function void check_result(rsp_t got);
      rsp_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.new_scalar_flags !== exp.new_scalar_flags) begin
        $display("%0t: scalar flags expected %h actual %h", $time,
                 exp.new_scalar_flags, got.new_scalar_flags);
        errors++;
      end
      if (got.new_vector_flags !== exp.new_vector_flags) begin
        $display("%0t: vector flags expected %h actual %h", $time,
                 exp.new_vector_flags, got.new_vector_flags);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  vcfu_req_if req_if();
  vcfu_rsp_if rsp_if();
  flag_scoreboard sb;
  bit hold_rsp, send_done;
  int idle_cycles;

  vector_compare_flag_unit dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .req_i (req_if.sink), .rsp_o (rsp_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Interesting operand values
  function automatic elem_t pick_value(logic is_float);
    elem_t ints[8] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                       32'h8000_0001, 32'h0000_0100, 32'hffff_ff00};
    elem_t flts[10] = '{32'h0, 32'h8000_0000, 32'h3f80_0000, 32'hbf80_0000,
                        32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'hff80_0001,
                        32'h0000_0001, 32'h8000_0001};
    case ($urandom_range(0, 2))
      0: return is_float ? flts[$urandom_range(0, 9)] : ints[$urandom_range(0, 7)];
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.command = 2'($urandom_range(0, 3));
    r.first_is_immediate = 1'($urandom_range(0, 1));
    r.first_is_float = 1'($urandom_range(0, 1));
    r.second_is_float = ($urandom_range(0, 3) == 0) ? ~r.first_is_float : r.first_is_float;
    r.first_scalar = pick_value(r.first_is_float);
    r.second_scalar = ($urandom_range(0, 3) == 0) ? r.first_scalar
                                                  : pick_value(r.second_is_float);
    r.first_vector = {pick_value(r.first_is_float), pick_value(r.first_is_float)};
    r.second_vector = {pick_value(r.second_is_float), pick_value(r.second_is_float)};
    if ($urandom_range(0, 3) == 0) r.second_vector = r.first_vector;
    r.old_scalar_flags = 7'($urandom_range(0, 127));
    r.old_vector_flags = 14'($urandom_range(0, 16383));
    return r;
  endfunction

  // Valid stays high between back-to-back requests
  task automatic send_request(req_t r, int gap);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
  endtask

  task automatic send_with_gap(req_t r);
    send_request(r, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13));
  endtask

  // Sender
  initial begin
    req_t r;
    sb = new();
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: every command, immediates, mixed types, NaN, signed zeros
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 5; k++) begin
        r = '0;
        r.command = 2'(c);
        r.first_is_immediate = (k == 4);
        r.first_is_float = (k == 1 || k == 2);
        r.second_is_float = (k != 0 && k != 3 ? 1'b1 : (k == 3));
        r.first_scalar = (k == 1) ? 32'h8000_0000 : (k == 2 ? 32'h7fc0_0000 : 32'h8000_0000);
        r.second_scalar = (k == 0) ? 32'h7fff_ffff : 32'h0;
        r.first_vector = {32'hffff_ffff, 32'h8000_0000};
        r.second_vector = {32'h7f80_0000, 32'h0};
        r.old_scalar_flags = 7'h7f;
        r.old_vector_flags = 14'h3fff;
        send_request(r, 0);
      end
    end
    for (int n = 0; n < 550; n++) begin
      if (n == 200) begin
        // block fills while receiver holds off
        hold_rsp = 1'b1;
      end
      if (n == 400) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
      send_with_gap(random_request());
    end
    req_if.valid <= 1'b0;
    send_done = 1'b1;
  end

  // Receiver
  initial begin
    int gap;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      if (hold_rsp) begin
        gap = 60;
        hold_rsp = 1'b0;
      end
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      sb.check_result(rsp_if.data);
    end
  end

  // Watchdog and end of run
  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("vector_compare_flag_unit regression: fail");
        $finish;
      end
      if (send_done && sb.pending.size() == 0) begin
        repeat (4) @(posedge clk_i);
        if (sb.errors == 0 && !rsp_if.valid) begin
          $display("vector_compare_flag_unit regression: pass");
        end else begin
          $display("vector_compare_flag_unit regression: fail");
        end
        $finish;
      end
    end
  end

endmodule

>>> sim.f
hw/rtl/vcfu_pkg.sv
hw/rtl/vcfu_req_if.sv
hw/rtl/vcfu_rsp_if.sv
hw/rtl/vcfu_lane.sv
hw/rtl/vector_compare_flag_unit.sv
tb/sv/vector_compare_flag_unit_tb.sv
